// ===== src/dtp_pkg.sv =====
// Shared types and constants for the decimal integer token parser.
// No dependencies.
package dtp_pkg;

	// digits kept before further digits count as zero (1..9)
	localparam int unsigned MaxDigits = 8;

	localparam logic [30:0] MAG_LIMIT  = 31'h7fff_ffff;
	localparam logic [7:0]  CHAR_MINUS = 8'h2d;
	localparam logic [7:0]  CHAR_PLUS  = 8'h2b;
	localparam logic [7:0]  CHAR_ZERO  = 8'h30;
	localparam logic [7:0]  DIGIT_MAX  = 8'd9;
	localparam logic [3:0]  COUNT_MAX  = 4'd15;

	typedef struct packed {
		logic        active;
		logic        sign_allowed;
		logic        negative;
		logic [30:0] magnitude;
		logic [3:0]  digit_count;
		logic [7:0]  token_start;
		logic [7:0]  position;
		logic        saturated;
	} tok_state_t;

	typedef struct packed {
		logic               valid;
		logic               found;
		logic signed [31:0] value;
		logic [7:0]         next_offset;
		logic               overflow;
	} tok_result_t;

endpackage

// ===== src/dtp_step.sv =====
// Per-character token step: next parser state and the optional result.
// Depends on dtp_pkg.
module dtp_step #(
	parameter int unsigned MAX_DIGITS = dtp_pkg::MaxDigits
) (
	input  logic                first,
	input  logic [7:0]          start_offset,
	input  logic [7:0]          character,
	input  dtp_pkg::tok_state_t cur,
	output dtp_pkg::tok_state_t nxt,
	output dtp_pkg::tok_result_t res
);
	import dtp_pkg::*;

	localparam logic [3:0] COUNT_KEEP = 4'(MAX_DIGITS);

	tok_state_t  st;
	logic [7:0]  digit;
	logic [3:0]  cnt_new;
	logic [34:0] prod;
	logic        is_sign;

	always_comb begin
		st = cur;
		if (first) begin
			st.active       = 1'b1;
			st.sign_allowed = 1'b1;
			st.negative     = 1'b0;
			st.magnitude    = '0;
			st.digit_count  = '0;
			st.token_start  = start_offset;
			st.position     = '0;
			st.saturated    = 1'b0;
		end

		digit   = character - CHAR_ZERO;
		is_sign = (character == CHAR_MINUS) || (character == CHAR_PLUS);
		cnt_new = (st.digit_count < COUNT_MAX) ? st.digit_count + 4'd1 : st.digit_count;
		// x10 as shift-and-add
		prod = {1'b0, st.magnitude, 3'b000} + {3'b000, st.magnitude, 1'b0};
		if (cnt_new <= COUNT_KEEP)
			prod = prod + {31'd0, digit[3:0]};

		nxt = st;
		res = '0;
		if (st.active) begin
			if (st.sign_allowed && is_sign) begin
				nxt.sign_allowed = 1'b0;
				nxt.negative     = (character == CHAR_MINUS);
				nxt.position     = st.position + 8'd1;
			end else if (digit <= DIGIT_MAX) begin
				nxt.sign_allowed = 1'b0;
				nxt.digit_count  = cnt_new;
				if (st.saturated || (prod > {4'd0, MAG_LIMIT})) begin
					nxt.magnitude = MAG_LIMIT;
					nxt.saturated = 1'b1;
				end else begin
					nxt.magnitude = prod[30:0];
				end
				nxt.position = st.position + 8'd1;
			end else begin
				// terminator closes the token
				nxt.sign_allowed = 1'b0;
				nxt.active       = 1'b0;
				res.valid        = 1'b1;
				if (st.digit_count == 4'd0) begin
					res.next_offset = st.token_start;
				end else begin
					res.found       = 1'b1;
					res.value       = st.negative ? -$signed({1'b0, st.magnitude})
						: $signed({1'b0, st.magnitude});
					res.next_offset = st.token_start + st.position;
					res.overflow    = st.saturated;
				end
			end
		end
	end

endmodule

// ===== src/decimal_integer_token_parser.sv =====
// Decimal integer token parser: input register, step logic, result register.
// out_valid rises once the terminating character has passed the input register and the result register.
// Throughput: one character per cycle, sustained, with no stall at the output.
// Reset (arst_n low, asynchronous): no token open, both pipeline registers empty.
// Depends on dtp_pkg and dtp_step.
module decimal_integer_token_parser #(
	parameter int unsigned MAX_DIGITS = dtp_pkg::MaxDigits
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               first,
	input  logic [7:0]         start_offset,
	input  logic [7:0]         character,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic signed [31:0] value,
	output logic [7:0]         next_offset,
	output logic               overflow
);
	import dtp_pkg::*;

	// stage 1: registered input character
	logic        valid_s1;
	logic        first_s1;
	logic [7:0]  start_s1;
	logic [7:0]  char_s1;

	// parser state carried between characters
	tok_state_t  state_q;
	tok_state_t  state_nxt;
	tok_result_t step_res;

	// result register
	logic        out_valid_q;
	tok_result_t res_q;

	// stage 1 retires when the result register can take a transfer; items with
	// no result also wait for that, which keeps the control trivial
	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	dtp_step #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_step (
		.first        (first_s1),
		.start_offset (start_s1),
		.character    (char_s1),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			first_s1 <= first;
			start_s1 <= start_offset;
			char_s1  <= character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_res.valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			res_q <= step_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = res_q.found;
	assign value       = res_q.value;
	assign next_offset = res_q.next_offset;
	assign overflow    = res_q.overflow;

	// a transfer without digits carries zero value and no overflow
	a_empty_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> value == 32'sd0 && !overflow)
		else $error("empty token with nonzero payload");

	// overflow only on a token that had digits
	a_ovf_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> found)
		else $error("overflow without digits");

	// a terminator closes the token
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res.valid |=> !state_q.active)
		else $error("token still open after terminator");

	// input side only stalls with a held character
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

endmodule

// ===== sim/decimal_integer_token_parser_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for decimal_integer_token_parser: random bursts of tokens and noise,
// a scoreboard class that tracks the token state and checks each result transfer in order.
// Depends on dtp_pkg and the parser RTL; reads no files.
module decimal_integer_token_parser_test;
	import dtp_pkg::*;

	localparam int TOKEN_CHARS  = 1750;  // characters sent inside random tokens
	localparam int STALL_LIMIT  = 1000;  // cycles with no transfer before giving up
	localparam int HOLD_CYCLES  = 100;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 8;     // settle time after the last result

	// one expected or observed result transfer
	typedef struct packed {
		logic               found;
		logic signed [31:0] value;
		logic [7:0]         next_offset;
		logic               overflow;
	} parse_result_t;

	// Token state mirror plus the queue of results still owed by the block.
	class token_scoreboard;
		bit                 active;
		bit                 sign_ok;
		bit                 negative;
		bit                 saturated;
		bit [30:0]          magnitude;
		bit [3:0]           digit_count;
		bit [7:0]           token_start;
		bit [7:0]           position;
		parse_result_t      owed_q[$];
		int                 errors;
		int                 n_chars;
		int                 n_results;
		int                 n_saturated;
		int                 n_negative;
		int                 n_empty;

		function int pending();
			return owed_q.size();
		endfunction

		task report_mismatch(input string msg);
			if (errors < 50)
				$display("mismatch at %0t ns: %s", $time, msg);
			errors++;
		endtask

		// Advance the token state on one accepted character; queue a result on a terminator.
		function void note_char(input bit f, input bit [7:0] off, input bit [7:0] ch);
			bit [7:0]      digit;
			bit [63:0]     grown;
			parse_result_t r;
			n_chars++;
			if (f) begin
				active      = 1'b1;
				sign_ok     = 1'b1;
				negative    = 1'b0;
				magnitude   = '0;
				digit_count = '0;
				token_start = off;
				position    = '0;
				saturated   = 1'b0;
			end
			if (!active)
				return;
			if (sign_ok && (ch == CHAR_MINUS || ch == CHAR_PLUS)) begin
				sign_ok  = 1'b0;
				negative = (ch == CHAR_MINUS);
				position++;
				return;
			end
			sign_ok = 1'b0;
			digit = ch - CHAR_ZERO;
			if (digit <= DIGIT_MAX) begin
				if (digit_count != COUNT_MAX)
					digit_count++;
				grown = 64'(magnitude) * 10;
				// digits past the kept count only scale the magnitude
				if (digit_count <= MaxDigits)
					grown += 64'(digit);
				if (saturated || grown > 64'(MAG_LIMIT)) begin
					magnitude = MAG_LIMIT;
					saturated = 1'b1;
				end else begin
					magnitude = grown[30:0];
				end
				position++;
				return;
			end
			active = 1'b0;
			if (digit_count == 0) begin
				r.found       = 1'b0;
				r.value       = '0;
				r.next_offset = token_start;
				r.overflow    = 1'b0;
			end else begin
				r.found       = 1'b1;
				r.value       = negative ? 32'(0) - 32'(magnitude) : 32'(magnitude);
				r.next_offset = token_start + position;
				r.overflow    = saturated;
			end
			owed_q.push_back(r);
		endfunction

		task check_result(input logic f, input logic signed [31:0] v, input logic [7:0] nxt,
				input logic ov);
			parse_result_t e;
			if (owed_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result found=%b value=%0d next_offset=%0d",
					f, v, nxt));
				return;
			end
			e = owed_q.pop_front();
			n_results++;
			if (e.overflow)
				n_saturated++;
			if (e.value < 0)
				n_negative++;
			if (!e.found)
				n_empty++;
			if (f !== e.found)
				report_mismatch($sformatf("found %b, want %b", f, e.found));
			if (v !== e.value)
				report_mismatch($sformatf("value %0d, want %0d", v, e.value));
			if (nxt !== e.next_offset)
				report_mismatch($sformatf("next_offset %0d, want %0d", nxt, e.next_offset));
			if (ov !== e.overflow)
				report_mismatch($sformatf("overflow %b, want %b", ov, e.overflow));
		endtask

		task check_drained();
			if (owed_q.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", owed_q.size()));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               first;
	logic [7:0]         start_offset;
	logic [7:0]         character;
	logic               out_valid;
	logic               out_stall;
	logic               found;
	logic signed [31:0] value;
	logic [7:0]         next_offset;
	logic               overflow;

	token_scoreboard sb = new;

	int token_chars = 0;  // characters sent inside random tokens
	int burst_left  = 0;  // transfers left in the current sender burst
	bit hold_go     = 1'b0;
	bit hold_done   = 1'b0;

	decimal_integer_token_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.first       (first),
		.start_offset(start_offset),
		.character   (character),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.value       (value),
		.next_offset (next_offset),
		.overflow    (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: both channels sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(found, value, next_offset, overflow);
		if (in_valid && !in_stall)
			sb.note_char(first, start_offset, character);
	end

	// Watchdog: any transfer on either side restarts the count.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: %0d cycles without a transfer", quiet);
		$display("FAILURE");
		$finish;
	end

	// Receiver: segments of free flow, light stalls and heavy stalls; one long hold-off
	// on request so the pipeline backs up into in_stall.
	initial begin : receiver
		int mode;
		int seg_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_go && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			mode    = $urandom_range(0, 3);
			seg_len = $urandom_range(1, 40);
			repeat (seg_len) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 1);
					2: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(negedge clk);
			end
		end
	end

	// One input transfer. Entered at a falling edge, returns at a falling edge.
	// Bursts of back-to-back offers with random gaps between them.
	task automatic send_char(input logic f, input logic [7:0] off, input logic [7:0] ch);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			repeat (gap) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			// now and then a long stretch with no idling at all
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
		end
		in_valid     <= 1'b1;
		first        <= f;
		start_offset <= off;
		character    <= ch;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	// Well-formed token with random content: optional sign, digits, terminator.
	// Some end on a sign, some are left open for the next token to drop.
	task automatic send_token();
		logic [7:0] word[$];
		logic [7:0] off;
		logic [7:0] ch;
		int         ndig;
		int         pick;
		off  = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 3);
		if (pick == 0)
			word.push_back(CHAR_MINUS);
		else if (pick == 1)
			word.push_back(CHAR_PLUS);
		pick = $urandom_range(0, 19);
		if (pick < 2)
			ndig = 0;
		else if (pick < 17)
			ndig = $urandom_range(1, 6);
		else
			ndig = $urandom_range(7, 18);  // past the kept digits, saturation, count limit
		repeat (ndig)
			word.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
		pick = $urandom_range(0, 15);
		if (pick == 1)
			word.push_back(CHAR_MINUS);
		else if (pick == 2)
			word.push_back(CHAR_PLUS);
		else if (pick != 0) begin
			do
				ch = 8'($urandom_range(0, 255));
			while (8'(ch - CHAR_ZERO) <= DIGIT_MAX);
			word.push_back(ch);
		end
		foreach (word[i])
			send_char(i == 0, off, word[i]);
		token_chars += word.size();
	endtask

	// Stop offering and wait until every owed result has been transferred.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int pick;
		bit paused;
		paused       = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		first        = 1'b0;
		start_offset = '0;
		character    = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: idle character with nothing open
		send_char(1'b0, 8'd0, 8'hff);
		// negative zero, offset wraps past 255
		send_char(1'b1, 8'd255, CHAR_MINUS);
		send_char(1'b0, 8'd0, CHAR_ZERO);
		send_char(1'b0, 8'd0, 8'h20);
		// second sign ends a token with no digits
		send_char(1'b1, 8'd0, CHAR_PLUS);
		send_char(1'b0, 8'd0, CHAR_MINUS);
		// terminator as the very first character
		send_char(1'b1, 8'd7, 8'h00);
		// open token dropped by a new one, which then saturates
		send_char(1'b1, 8'd3, CHAR_ZERO + 8'd1);
		send_char(1'b0, 8'd3, CHAR_ZERO + 8'd2);
		send_char(1'b1, 8'd9, CHAR_ZERO + DIGIT_MAX);
		repeat (10)
			send_char(1'b0, 8'd9, CHAR_ZERO + DIGIT_MAX);
		send_char(1'b0, 8'd9, 8'hff);
		// digit after the token closed is ignored
		send_char(1'b0, 8'd200, CHAR_ZERO + 8'd5);

		// random part
		while (token_chars < TOKEN_CHARS) begin
			if (!hold_go && token_chars >= 300)
				hold_go = 1'b1;
			if (!paused && token_chars >= 900) begin
				paused = 1'b1;
				wait_drained();
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// noise: first low, any character and offset
				repeat ($urandom_range(1, 4))
					send_char(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end else begin
				send_token();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		sb.check_drained();
		$display("Run covered %0d character transfers and %0d result transfers", sb.n_chars,
			sb.n_results);
		$display("  %0d saturated, %0d negative, %0d without digits, %0d mismatches",
			sb.n_saturated, sb.n_negative, sb.n_empty, sb.errors);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
